// ----- sv/eled_pkg.sv -----
// shared types and constants of the echoing line editor
`default_nettype none

package eled_pkg;

    localparam int FILL_W = 5;
    localparam int CHAR_W = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTRICT_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_LOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_HIGH = 2'd3;

    localparam logic [5:0] CAPACITY_RESET = 6'd32;

    localparam logic [7:0] CHR_BS = 8'd8;
    localparam logic [7:0] CHR_LF = 8'd10;
    localparam logic [7:0] CHR_CR = 8'd13;
    localparam logic [7:0] CHR_SP = 8'd32;
    localparam logic [7:0] CHR_DEL = 8'd127;
    localparam logic [7:0] CHR_HIGH_BASE = 8'd96;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_ERROR  = 2'd0,
        OP_DELETE = 2'd1,
        OP_RETURN = 2'd2,
        OP_PRINT  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] ch;
    } t_cmd;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic [FILL_W-1:0] len;
        logic              last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL_SP,
        ST_DEL_BS,
        ST_LF,
        ST_LINE,
        ST_END
    } t_bstate;

endpackage

`default_nettype wire

// ----- sv/eled_ram.sv -----
// generic single write, single registered read memory
`default_nettype none

module eled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/eled_fifo.sv -----
// two-entry command queue between front and back
`default_nettype none

module eled_fifo import eled_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/eled_front.sv -----
// front end: takes received words, classifies them and filters by the allowed set
`default_nettype none

module eled_front import eled_pkg::*; (
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_rx_error,
    input  wire logic        i_restrict_enable,
    input  wire logic [63:0] i_allowed_low,
    input  wire logic [30:0] i_allowed_high,
    input  wire logic        i_queue_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic       keep;
    logic       allowed;
    logic [7:0] low_off;
    logic [7:0] high_off;

    assign low_off  = i_rx_byte - CHR_SP;
    assign high_off = i_rx_byte - CHR_HIGH_BASE;

    always_comb begin
        if (!i_restrict_enable) begin
            allowed = 1'b1;
        end else if (i_rx_byte < CHR_HIGH_BASE) begin
            allowed = i_allowed_low[low_off[5:0]];
        end else begin
            allowed = i_allowed_high[high_off[4:0]];
        end
    end

    always_comb begin
        o_cmd.ch = i_rx_byte[6:0];
        o_cmd.op = OP_PRINT;
        keep     = 1'b0;
        if (i_rx_error || i_rx_byte[7]) begin
            o_cmd.op = OP_ERROR;
            keep     = 1'b1;
        end else if (i_rx_byte == CHR_DEL) begin
            o_cmd.op = OP_DELETE;
            keep     = 1'b1;
        end else if (i_rx_byte == CHR_CR) begin
            o_cmd.op = OP_RETURN;
            keep     = 1'b1;
        end else if (i_rx_byte >= CHR_SP) begin
            o_cmd.op = OP_PRINT;
            keep     = allowed;
        end
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full && keep;

endmodule

`default_nettype wire

// ----- sv/eled_back.sv -----
// back end: line store, fill index and output sequencer
`default_nettype none

module eled_back import eled_pkg::*; #(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_pop,
    input  wire logic [5:0] i_line_capacity,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_item           o_item
);

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int CAP_LIM = (LINE_DEPTH < 32) ? LINE_DEPTH : 32;

    t_bstate           r_state;
    t_bstate           n_state;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_idx;
    logic [FILL_W-1:0] n_idx;
    logic              r_out_valid;
    t_item             r_out;

    logic              out_free;
    logic              emit;
    t_item             item;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [5:0]        cap_eff;
    logic              room;

    assign out_free = !r_out_valid || !i_out_stall;
    assign cap_eff  = (i_line_capacity > 6'(CAP_LIM)) ? 6'(CAP_LIM) : i_line_capacity;
    assign room     = ({1'b0, r_fill} + 6'd1) < cap_eff;

    eled_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(r_fill)),
        .i_wr_data ({1'b0, i_cmd.ch}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        emit      = 1'b0;
        item      = '{kind: KIND_ECHO, ch: '0, len: '0, last: 1'b0};
        o_cmd_pop = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = ADDR_W'(r_idx);
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_ERROR: begin
                            emit      = 1'b1;
                            item.kind = KIND_ERROR;
                            item.last = 1'b1;
                        end
                        OP_DELETE: begin
                            if (r_fill != '0) begin
                                n_fill  = r_fill - FILL_W'(1);
                                emit    = 1'b1;
                                item.ch = CHR_BS;
                                n_state = ST_DEL_SP;
                            end
                        end
                        OP_RETURN: begin
                            emit    = 1'b1;
                            item.ch = CHR_CR;
                            n_state = ST_LF;
                        end
                        OP_PRINT: begin
                            if (room) begin
                                wr_en     = 1'b1;
                                n_fill    = r_fill + FILL_W'(1);
                                emit      = 1'b1;
                                item.ch   = {1'b0, i_cmd.ch};
                                item.last = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_DEL_SP: begin
                if (out_free) begin
                    emit    = 1'b1;
                    item.ch = CHR_SP;
                    n_state = ST_DEL_BS;
                end
            end
            ST_DEL_BS: begin
                if (out_free) begin
                    emit      = 1'b1;
                    item.ch   = CHR_BS;
                    item.last = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_LF: begin
                if (out_free) begin
                    emit    = 1'b1;
                    item.ch = CHR_LF;
                    n_idx   = '0;
                    rd_addr = '0;
                    if (r_fill == '0) begin
                        n_state = ST_END;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = ST_LINE;
                    end
                end
            end
            ST_LINE: begin
                if (out_free) begin
                    emit      = 1'b1;
                    item.kind = KIND_LINE;
                    item.ch   = rd_data;
                    n_idx     = r_idx + FILL_W'(1);
                    rd_addr   = ADDR_W'(n_idx);
                    if (n_idx == r_fill) begin
                        n_state = ST_END;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    emit      = 1'b1;
                    item.kind = KIND_END;
                    item.len  = r_fill;
                    item.last = 1'b1;
                    n_fill    = '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= item;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_item      = r_out;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_fill} < 6'(CAP_LIM))
        else $error("fill index beyond usable capacity");

    a_line_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LINE) |-> (r_idx < r_fill))
        else $error("line readout beyond fill index");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && out_free) |=> (r_fill == '0 && r_out.last))
        else $error("line end did not clear the line");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd_pop)
        else $error("command taken while sequencer busy");
`endif

endmodule

`default_nettype wire

// ----- sv/echoing_line_editor_top.sv -----
// top level of the echoing line editor
//
//  channel  direction  handshake                        word
//  in       input      i_in_valid / o_in_stall          i_rx_byte, i_rx_error
//  out      output     o_out_valid / i_out_stall        o_item_kind, o_out_char,
//                                                       o_line_length, o_last_of_run
//  cfg      input      i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
//  front takes one word per cycle into a two-entry queue; stall only while the queue is full
//  back sequencer sends one word per cycle, while out is not stalled, through a single output register
//  error or printable: one word; delete: BS SP BS; return: CR, LF, line characters, end word
//  synchronous reset empties the line and loads register defaults; the line store is not cleared
//  an output stall holds the sequencer; the queue absorbs up to two more input words
`default_nettype none

module echoing_line_editor_top import eled_pkg::*; #(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_rx_error,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [1:0]                 o_item_kind,
    output logic [7:0]                 o_out_char,
    output logic [4:0]                 o_line_length,
    output logic                       o_last_of_run,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [5:0]  r_line_capacity;
    logic        r_restrict_enable;
    logic [63:0] r_allowed_low;
    logic [30:0] r_allowed_high;

    logic  push;
    logic  queue_full;
    logic  pop;
    logic  cmd_valid;
    t_cmd  push_cmd;
    t_cmd  head_cmd;
    t_item item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_capacity   <= CAPACITY_RESET;
            r_restrict_enable <= 1'b0;
            r_allowed_low     <= '0;
            r_allowed_high    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINE_CAPACITY:   r_line_capacity   <= i_cfg_data[5:0];
                CFG_RESTRICT_ENABLE: r_restrict_enable <= i_cfg_data[0];
                CFG_ALLOWED_LOW:     r_allowed_low     <= i_cfg_data;
                CFG_ALLOWED_HIGH:    r_allowed_high    <= i_cfg_data[30:0];
            endcase
        end
    end

    eled_front u_front (
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .i_rx_error        (i_rx_error),
        .i_restrict_enable (r_restrict_enable),
        .i_allowed_low     (r_allowed_low),
        .i_allowed_high    (r_allowed_high),
        .i_queue_full      (queue_full),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    eled_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    eled_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (head_cmd),
        .o_cmd_pop       (pop),
        .i_line_capacity (r_line_capacity),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_item          (item)
    );

    assign o_item_kind   = item.kind;
    assign o_out_char    = item.ch;
    assign o_line_length = item.len;
    assign o_last_of_run = item.last;

endmodule

`default_nettype wire

// ----- tb/echoing_line_editor_top_test.sv -----
// testbench of the echoing line editor: directed and random characters, checked against a predictor
`timescale 1ns / 100ps

module echoing_line_editor_top_test;
    import eled_pkg::*;

    localparam int LINE_DEPTH = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT = 2000;
    localparam int TARGET_WORDS = 300;

    class line_echo_board;
        logic [7:0]  line_chars [LINE_DEPTH];
        int          fill;
        logic [5:0]  cap_reg;
        bit          restrict_on;
        logic [63:0] mask_low;
        logic [30:0] mask_high;
        t_item       echo_due [$];
        int          mismatches;

        function new();
            fill = 0;
            cap_reg = CAPACITY_RESET;
            restrict_on = 1'b0;
            mask_low = '0;
            mask_high = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_LINE_CAPACITY: cap_reg = d[5:0];
                CFG_RESTRICT_ENABLE: restrict_on = d[0];
                CFG_ALLOWED_LOW: mask_low = d;
                CFG_ALLOWED_HIGH: mask_high = d[30:0];
                default: ;
            endcase
        endfunction

        function void add(t_kind k, logic [7:0] c, logic [4:0] n);
            t_item w;
            w.kind = k;
            w.ch = c;
            w.len = n;
            w.last = 1'b0;
            echo_due.push_back(w);
        endfunction

        // returns the number of words this character produces
        function int take_char(logic [7:0] b, logic e);
            int    n0;
            int    room;
            bit    ok;
            t_item w;
            n0 = echo_due.size();
            if (e || b[7]) begin
                add(KIND_ERROR, 8'd0, 5'd0);
            end else if (b == CHR_DEL) begin
                if (fill > 0) begin
                    fill--;
                    add(KIND_ECHO, CHR_BS, 5'd0);
                    add(KIND_ECHO, CHR_SP, 5'd0);
                    add(KIND_ECHO, CHR_BS, 5'd0);
                end
            end else if (b == CHR_CR) begin
                add(KIND_ECHO, CHR_CR, 5'd0);
                add(KIND_ECHO, CHR_LF, 5'd0);
                for (int i = 0; i < fill && i < 31; i++) begin
                    add(KIND_LINE, line_chars[5'(i)], 5'd0);
                end
                add(KIND_END, 8'd0, 5'(fill));
                fill = 0;
            end else if (b >= CHR_SP) begin
                if (!restrict_on) begin
                    ok = 1'b1;
                end else if (b < CHR_HIGH_BASE) begin
                    ok = mask_low[6'(b - CHR_SP)];
                end else begin
                    ok = mask_high[5'(b - CHR_HIGH_BASE)];
                end
                room = (cap_reg > 6'd32) ? 32 : int'(cap_reg);
                if (fill + 1 < room && fill < LINE_DEPTH && ok) begin
                    line_chars[5'(fill)] = b;
                    fill++;
                    add(KIND_ECHO, b, 5'd0);
                end
            end
            if (echo_due.size() > n0) begin
                w = echo_due.pop_back();
                w.last = 1'b1;
                echo_due.push_back(w);
            end
            return echo_due.size() - n0;
        endfunction

        function void match_item(logic [1:0] k, logic [7:0] c, logic [4:0] n, logic l);
            t_item w;
            if (echo_due.size() == 0) begin
                $error("unexpected word: item_kind %0d out_char %0d", k, c);
                mismatches++;
            end else begin
                w = echo_due.pop_front();
                if (k !== w.kind) begin
                    $error("item_kind: expected %0d, got %0d", w.kind, k);
                    mismatches++;
                end
                if (c !== w.ch) begin
                    $error("out_char: expected %0d, got %0d", w.ch, c);
                    mismatches++;
                end
                if (n !== w.len) begin
                    $error("line_length: expected %0d, got %0d", w.len, n);
                    mismatches++;
                end
                if (l !== w.last) begin
                    $error("last_of_run: expected %0d, got %0d", w.last, l);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_rx_byte;
    logic                  i_rx_error;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_item_kind;
    logic [7:0]            o_out_char;
    logic [4:0]            o_line_length;
    logic                  o_last_of_run;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    line_echo_board board;
    bit             hold_req;
    bit             dense;
    int             busy_words;

    echoing_line_editor_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_rx_error   (i_rx_error),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_item_kind  (o_item_kind),
        .o_out_char   (o_out_char),
        .o_line_length(o_line_length),
        .o_last_of_run(o_last_of_run),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (dense || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        i_rx_error <= e;
        do @(posedge i_clk); while (o_in_stall);
        void'(board.take_char(b, e));
        busy_words++;
    endtask

    // waits for the last expected word, then lets the block settle
    task automatic wait_idle(input int settle);
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (board.echo_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, d);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // output side stall pattern, with one long hold on request
    initial begin
        int hold_left;
        int free_left;
        int r;
        hold_left = 0;
        free_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (free_left > 0) begin
                free_left--;
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(99);
                if (r < 8) begin
                    free_left = $urandom_range(20, 80);
                    i_out_stall <= 1'b0;
                end else if (r < 11) begin
                    hold_left = $urandom_range(15, 50);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= (r < 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.match_item(o_item_kind, o_out_char, o_line_length, o_last_of_run);
        end
    end

    always @(posedge i_clk) begin
        int quiet;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= IDLE_LIMIT) begin
            $display("echoing_line_editor_top test failed");
            $finish;
        end
    end

    initial begin
        int          r;
        int          n;
        int          cr_pct;
        logic [7:0]  b;
        logic        e;
        logic [63:0] d;
        board = new();
        busy_words = 0;
        hold_req = 1'b0;
        dense = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte = '0;
        i_rx_error = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LINE_CAPACITY;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // defaults: empty delete, edges of printable range, errors, controls
        send_word(CHR_DEL, 1'b0);
        send_word(8'd65, 1'b0);
        send_word(CHR_SP, 1'b0);
        send_word(8'd126, 1'b0);
        send_word(CHR_DEL, 1'b0);
        send_word(8'd66, 1'b1);
        send_word(8'd128, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(CHR_LF, 1'b0);
        send_word(8'd31, 1'b0);
        send_word(CHR_CR, 1'b0);
        send_word(CHR_CR, 1'b0);

        // capacity lowered below the current line, then smallest usable line, then zero capacity
        send_word(8'd97, 1'b0);
        send_word(8'd98, 1'b0);
        send_word(8'd99, 1'b0);
        wait_idle(16);
        write_reg(CFG_LINE_CAPACITY, 64'd2);
        send_word(8'd120, 1'b0);
        send_word(CHR_DEL, 1'b0);
        send_word(CHR_CR, 1'b0);
        send_word(8'd121, 1'b0);
        send_word(8'd122, 1'b0);
        send_word(CHR_CR, 1'b0);
        wait_idle(16);
        write_reg(CFG_LINE_CAPACITY, 64'd0);
        send_word(8'd122, 1'b0);
        send_word(CHR_CR, 1'b0);

        // restricted set: space, underscore and tilde only
        wait_idle(16);
        write_reg(CFG_LINE_CAPACITY, 64'd32);
        write_reg(CFG_ALLOWED_LOW, 64'h8000_0000_0000_0001);
        write_reg(CFG_ALLOWED_HIGH, 64'h4000_0000);
        write_reg(CFG_RESTRICT_ENABLE, 64'd1);
        send_word(8'd126, 1'b0);
        send_word(CHR_SP, 1'b0);
        send_word(8'd95, 1'b0);
        send_word(8'd65, 1'b0);
        send_word(8'd96, 1'b0);
        send_word(8'd97, 1'b0);
        send_word(CHR_CR, 1'b0);

        for (int phase = 0; busy_words < TARGET_WORDS; phase++) begin
            wait_idle(16);
            r = $urandom_range(99);
            if (r < 10) begin
                n = 2;
            end else if (r < 22) begin
                n = 32;
            end else if (r < 27) begin
                n = $urandom_range(0, 1);
            end else if (r < 34) begin
                n = $urandom_range(33, 63);
            end else begin
                n = $urandom_range(3, 31);
            end
            d = {$urandom, $urandom};
            write_reg(CFG_LINE_CAPACITY, {d[63:6], 6'(n)});
            d = {$urandom, $urandom};
            write_reg(CFG_RESTRICT_ENABLE, {d[63:1], 1'($urandom_range(99) < 35)});
            r = $urandom_range(99);
            if (r < 20) begin
                d = '1;
            end else if (r < 30) begin
                d = '0;
            end else begin
                d = {$urandom, $urandom} | {$urandom, $urandom};
            end
            write_reg(CFG_ALLOWED_LOW, d);
            d = ($urandom_range(99) < 20) ? '1 : {$urandom, $urandom} | {$urandom, $urandom};
            write_reg(CFG_ALLOWED_HIGH, d);

            dense = ($urandom_range(3) == 0);
            cr_pct = $urandom_range(2, 15);
            if (phase == 3) begin
                hold_req = 1'b1;
            end
            n = $urandom_range(20, 40);
            repeat (n) begin
                r = $urandom_range(99);
                e = 1'b0;
                if (r < cr_pct) begin
                    b = CHR_CR;
                end else if (r < cr_pct + 8) begin
                    b = CHR_DEL;
                end else if (r < cr_pct + 12) begin
                    b = 8'($urandom_range(0, 255));
                    e = 1'b1;
                end else if (r < cr_pct + 15) begin
                    b = 8'($urandom_range(128, 255));
                end else if (r < cr_pct + 18) begin
                    b = 8'($urandom_range(0, 31));
                end else begin
                    b = 8'($urandom_range(32, 126));
                end
                send_word(b, e);
            end
        end

        wait_idle(40);
        if (board.mismatches == 0 && board.echo_due.size() == 0) begin
            $display("echoing_line_editor_top test passed");
        end else begin
            $display("echoing_line_editor_top test failed");
        end
        $finish;
    end

endmodule
